// File: rtl/ntre_pkg.sv
// Package: shared types and constants for the neighbor table block.
`timescale 1ns / 1ps
package ntre_pkg;
  localparam int MacW = 48;
  localparam int RssiW = 8;
  localparam int TimeW = 32;
  localparam int CntW = 5;
  localparam int EntW = MacW + RssiW + TimeW;
  localparam logic [TimeW-1:0] TimeoutReset = 32'd30000;
  localparam logic [0:0] OpPacket = 1'b0;
  localparam logic [0:0] OpSweep = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCAN,
    ST_EVRD,
    ST_EVSCAN,
    ST_SHRD,
    ST_SHIFT,
    ST_APPEND,
    ST_SUMRD,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [RssiW-1:0] average_rssi;
    logic [CntW-1:0] neighbor_count;
    logic [CntW-1:0] expired_count;
    logic evicted;
    logic matched;
  } result_t;
endpackage

// File: rtl/ntre_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
`timescale 1ns / 1ps
module ntre_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [$clog2((Depth > 1) ? Depth : 2)-1:0] waddr,
  input  logic [Width-1:0]                           wdata,
  input  logic [$clog2((Depth > 1) ? Depth : 2)-1:0] raddr,
  output logic [Width-1:0]                           rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/neighbor_table_rssi_evict.sv
// Top level: ordered neighbor table with weakest-RSSI eviction and expiry sweep.
//  channel | dir | fields
//  s_axis  | in  | tuser: op[0]; tdata: mac[47:0] rssi[55:48] now_ms[87:56]
//  m_axis  | out | tdata: matched[0] evicted[1] expired_count[6:2]
//                |       neighbor_count[11:7] average_rssi[19:12]
//  apb     | cfg | timeout_ms at address 0
// One word at a time. Packet: single-port table walks over N = TABLE_DEPTH entries
// (match scan, min scan, shift, mean sum), then an SW-bit restoring divider
// (SW = 9 + log2 N).
// Sweep: compact walk, sum walk and divider.
// Reset clears the state, result valid, count and timeout; table contents need no clearing.
// The result register holds while m_axis_tready is low; a new word is taken when it drains.
`timescale 1ns / 1ps
module neighbor_table_rssi_evict #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [87:0]  s_axis_tdata,   // mac, rssi, now_ms
  input  logic [0:0]   s_axis_tuser,   // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata,   // matched, evicted, expired_count,
                                       // neighbor_count, average_rssi, zero fill
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [0:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ntre_pkg::*;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW = AW + 1;
  localparam int SW = RssiW + IW;

  state_t state, state_next;
  logic [TimeW-1:0] timeout_ms;
  logic [IW-1:0] count, idx, widx, pos;
  logic in_op;
  logic [MacW-1:0] in_mac;
  logic signed [RssiW-1:0] in_rssi, min_rssi;
  logic [TimeW-1:0] in_now;
  logic matched, evicted;
  logic [CntW-1:0] expired;
  logic signed [SW-1:0] sum;
  logic [SW-1:0] dq, drem;
  logic [$clog2(SW+1)-1:0] dstep;
  logic neg;
  result_t res;
  logic out_valid;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EntW-1:0] wdata, rdata;
  logic [MacW-1:0] r_mac;
  logic signed [RssiW-1:0] r_rssi;
  logic [TimeW-1:0] r_seen;
  logic [TimeW-1:0] age;

  ntre_ram #(.Width(EntW), .Depth(TABLE_DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign {r_mac, r_rssi, r_seen} = rdata;
  assign age = in_now - r_seen;
  assign pready = 1'b1;
  assign prdata = timeout_ms;
  assign s_axis_tready = (state == ST_IDLE) && !out_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {4'd0, res};

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TimeoutReset;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      timeout_ms <= pwdata;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = ST_SRD;
      ST_SRD: state_next = (count == '0) ? ((in_op == OpSweep) ? ST_SUMRD : ST_APPEND)
                                         : ST_SCAN;
      ST_SCAN: begin
        if (in_op == OpSweep) begin
          if (idx + 1'b1 >= count) state_next = ST_SUMRD;
          else state_next = ST_SRD;
        end else if (r_mac == in_mac) begin
          state_next = ST_SUMRD;
        end else if (idx + 1'b1 >= count) begin
          state_next = (count >= IW'(TABLE_DEPTH)) ? ST_EVRD : ST_APPEND;
        end else begin
          state_next = ST_SRD;
        end
      end
      ST_EVRD: state_next = ST_EVSCAN;
      ST_EVSCAN: state_next = (idx + 1'b1 >= count) ? ST_SHRD : ST_EVRD;
      ST_SHRD: state_next = (idx + 1'b1 >= count) ? ST_APPEND : ST_SHIFT;
      ST_SHIFT: state_next = ST_SHRD;
      ST_APPEND: state_next = ST_SUMRD;
      ST_SUMRD: state_next = (count == '0) ? ST_OUT : ST_SUM;
      ST_SUM: state_next = (idx + 1'b1 >= count) ? ST_DIV : ST_SUMRD;
      ST_DIV: if (dstep == '0) state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = widx[AW-1:0];
    wdata = rdata;
    raddr = idx[AW-1:0];
    unique case (state)
      ST_SCAN: begin
        if (in_op == OpSweep) begin
          we = (age <= timeout_ms);
        end else if (r_mac == in_mac) begin
          we = 1'b1;
          waddr = idx[AW-1:0];
          wdata = {r_mac, in_rssi, in_now};
        end
      end
      ST_SHRD: raddr = AW'(idx + 1'b1);
      ST_SHIFT: begin
        we = 1'b1;
        waddr = idx[AW-1:0];
      end
      ST_APPEND: begin
        we = 1'b1;
        waddr = count[AW-1:0];
        wdata = {in_mac, in_rssi, in_now};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          {in_now, in_rssi, in_mac} <= s_axis_tdata;
          in_op <= s_axis_tuser[0];
          idx <= '0;
          widx <= '0;
          matched <= 1'b0;
          evicted <= 1'b0;
          expired <= '0;
        end
        ST_SCAN: begin
          if (in_op == OpSweep) begin
            if (age <= timeout_ms) widx <= widx + 1'b1;
            else expired <= expired + 1'b1;
            if (idx + 1'b1 >= count) begin
              count <= (age <= timeout_ms) ? widx + 1'b1 : widx;
              idx <= '0;
            end else idx <= idx + 1'b1;
          end else if (r_mac == in_mac) begin
            matched <= 1'b1;
            idx <= '0;
          end else if (idx + 1'b1 >= count) begin
            idx <= '0;
            pos <= '0;
          end else idx <= idx + 1'b1;
        end
        ST_EVSCAN: begin
          if (idx == '0 || r_rssi < min_rssi) begin
            min_rssi <= r_rssi;
            pos <= idx;
          end
          if (idx + 1'b1 >= count) idx <= (idx == '0 || r_rssi < min_rssi) ? idx : pos;
          else idx <= idx + 1'b1;
        end
        ST_SHRD: if (idx + 1'b1 >= count) begin
          count <= count - 1'b1;
          evicted <= 1'b1;
        end
        ST_SHIFT: idx <= idx + 1'b1;
        ST_APPEND: begin
          count <= count + 1'b1;
          idx <= '0;
        end
        ST_SUMRD: if (idx == '0) sum <= '0;
        ST_SUM: begin
          sum <= sum + SW'(r_rssi);
          if (idx + 1'b1 >= count) begin
            neg <= (sum + SW'(r_rssi)) < 0;
            dq <= ((sum + SW'(r_rssi)) < 0) ? SW'(-(sum + SW'(r_rssi)))
                                             : SW'(sum + SW'(r_rssi));
            drem <= '0;
            dstep <= ($clog2(SW+1))'(SW);
          end else idx <= idx + 1'b1;
        end
        ST_DIV: if (dstep != '0) begin
          if ({drem[SW-2:0], dq[SW-1]} >= SW'(count)) begin
            drem <= {drem[SW-2:0], dq[SW-1]} - SW'(count);
            dq <= {dq[SW-2:0], 1'b1};
          end else begin
            drem <= {drem[SW-2:0], dq[SW-1]};
            dq <= {dq[SW-2:0], 1'b0};
          end
          dstep <= dstep - 1'b1;
        end
        ST_OUT: begin
          out_valid <= 1'b1;
          res.matched <= matched;
          res.evicted <= evicted;
          res.expired_count <= expired;
          res.neighbor_count <= CntW'(count);
          res.average_rssi <= (count == '0) ? '0
                            : (neg ? RssiW'(-dq) : RssiW'(dq));
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= IW'(TABLE_DEPTH))
    else $error("count beyond depth");
  assert property (@(posedge clk) disable iff (rst) !(res.matched && res.evicted) || !out_valid)
    else $error("matched and evicted together");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == ST_IDLE)
    else $error("work while result pending");
endmodule
